[design/short_task_deadline_scheduler_unit_defines.svh]
// Assertion macros for the short-task deadline scheduler.
// Included by the top level; no other dependencies.
`ifndef SHORT_TASK_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH
`define SHORT_TASK_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH
`define STDS_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define STDS_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[design/stds_pkg.sv]
// Types and constants for the short-task deadline scheduler.
// No dependencies.
package stds_pkg;
    typedef enum logic [2:0] {
        CMD_INIT = 3'd0, CMD_ENABLE = 3'd1, CMD_RUNNING = 3'd2,
        CMD_STOPPING = 3'd3, CMD_ENQUEUE = 3'd4
    } cmd_t;

    localparam logic [2:0] REG_SIMPLE_MODE = 3'd0;
    localparam logic [2:0] REG_SOFTIRQ_ISOLATE = 3'd1;
    localparam logic [2:0] REG_AGING_DIVISOR = 3'd2;
    localparam logic [2:0] REG_MAX_REMAINING = 3'd3;
    localparam logic [2:0] REG_SHORT_TASK = 3'd4;
    localparam logic [2:0] REG_CPU_COUNT = 3'd5;

    localparam logic [39:0] DEF_MAX_REMAINING_NS = 40'd200000000;
    localparam logic [39:0] DEF_SHORT_TASK_NS = 40'd80000;
    localparam logic [63:0] NOMINAL_WEIGHT = 64'd100;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_slot;
        logic [63:0] now_ns;
        logic [24:0] slice_left;
        logic [13:0] task_weight;
        logic [11:0] task_cpu;
        logic        task_cpu_ok;
        logic        cpu_preselected;
        logic        is_softirq_thread;
    } in_item_t;

    typedef struct packed {
        logic        queued;
        logic [12:0] queue_id;
        logic [63:0] order_key;
        logic        fifo_order;
        logic        kick_cpu;
    } out_item_t;
endpackage

[design/short_task_deadline_scheduler_unit.sv]
// Top level of the short-task deadline scheduler: task table, sequencer, shared
// restoring divider. Depends on stds_pkg and the defines header.
//
//  channel | signals                 | payload
//  in      | in_valid / in_stall     | stds_pkg::in_item_t
//  out     | out_valid / out_stall   | stds_pkg::out_item_t
//  cfg     | cfg_we / cfg_index      | cfg_data (40 bits)
//
// Non-enqueue events pass S_READ, S_EXEC; stopping adds a 64-step division and charge.
// Enqueue runs two 64-step divisions on one shared divider, then S_KEYADD and S_OUT;
// a missing entry or simple mode goes from S_EXEC to S_OUT. Reset clears valid marks,
// vtime-written marks and global vtime, loads config defaults; init fills rst/stp/avg.
// in_stall stays high while an item is in work or a result waits.
`include "short_task_deadline_scheduler_unit_defines.svh"
module short_task_deadline_scheduler_unit #(
    parameter int TASK_SLOTS = 256,
    parameter int MAX_CPU = 4096,
    parameter int DEFAULT_SLICE_NS = 20000000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  stds_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output stds_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [39:0]          cfg_data
);
    import stds_pkg::*;

    localparam int SW = (TASK_SLOTS > 2) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [63:0] DEF_SLICE = 64'(DEFAULT_SLICE_NS);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EXEC, S_DIV, S_CHARGE, S_EST, S_KEY, S_KEYADD, S_OUT
    } state_t;

    state_t state_reg;
    in_item_t item_reg;
    out_item_t out_reg;
    logic out_valid_reg;
    logic div_second_reg;

    logic simple_reg, isolate_reg;
    logic [15:0] aging_reg;
    logic [39:0] maxr_reg, shortr_reg;
    logic [12:0] ncpu_reg;
    logic [63:0] gvt_reg;
    logic [TASK_SLOTS-1:0] valid_reg;
    logic [TASK_SLOTS-1:0] tvt_set_reg;

    logic [63:0] rst_mem [TASK_SLOTS];
    logic [63:0] stp_mem [TASK_SLOTS];
    logic [63:0] avg_mem [TASK_SLOTS];
    logic [63:0] tvt_mem [TASK_SLOTS];
    logic [63:0] rs_q, sp_q, av_q, tv_q;

    // shared restoring divider
    logic [63:0] quo_reg, dvs_reg;
    logic [64:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] est_reg;
    logic [64:0] rem_sh;
    logic [65:0] rem_try;

    logic [SW-1:0] sidx;
    logic slot_ok, entry_ok;
    logic [63:0] ncpu_eff, w_eff, used, ran, avg_new, adj_sum, maxr, shortr, adj;
    logic cpu_usable;
    out_item_t simple_out, key_out;

    assign sidx = item_reg.task_slot[SW-1:0];
    assign slot_ok = 32'(item_reg.task_slot) < TASK_SLOTS;
    assign entry_ok = slot_ok && valid_reg[sidx];
    assign ncpu_eff = (32'(ncpu_reg) < MAX_CPU) ? 64'(ncpu_reg) : 64'(MAX_CPU);
    assign cpu_usable = item_reg.task_cpu_ok && (64'(item_reg.task_cpu) < ncpu_eff);
    assign w_eff = (item_reg.task_weight == '0) ? 64'd1 : 64'(item_reg.task_weight);
    assign used = DEF_SLICE - 64'(item_reg.slice_left);
    assign ran = item_reg.now_ns - rs_q;
    assign avg_new = (av_q - (av_q >> 2)) + (ran >> 2);
    assign maxr = (maxr_reg == '0) ? 64'(DEF_MAX_REMAINING_NS) : 64'(maxr_reg);
    assign shortr = (shortr_reg == '0) ? 64'(DEF_SHORT_TASK_NS) : 64'(shortr_reg);
    assign adj_sum = est_reg + quo_reg;
    always_comb
    begin
        adj = (adj_sum < est_reg) ? '1 : adj_sum;
        if (adj > maxr)
            adj = maxr;
    end
    assign rem_sh = {rem_reg[63:0], quo_reg[63]};
    assign rem_try = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        simple_out = '0;
        simple_out.queued = 1'b1;
        simple_out.fifo_order = 1'b1;
        if (!((isolate_reg && item_reg.is_softirq_thread) || !cpu_usable))
        begin
            simple_out.queue_id = 13'(item_reg.task_cpu) + 13'd1;
            simple_out.kick_cpu = !item_reg.cpu_preselected;
        end
        key_out = '0;
        key_out.queued = 1'b1;
        key_out.order_key = gvt_reg + quo_reg;
        if (est_reg <= shortr && cpu_usable)
        begin
            key_out.queue_id = 13'(item_reg.task_cpu) + 13'd1;
            key_out.kick_cpu = !item_reg.cpu_preselected;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ && slot_ok)
        begin
            rs_q <= rst_mem[sidx];
            sp_q <= stp_mem[sidx];
            av_q <= avg_mem[sidx];
            tv_q <= tvt_set_reg[sidx] ? tvt_mem[sidx] : '0;
        end
        if (state_reg == S_EXEC && slot_ok)
        begin
            unique case (item_reg.command)
                CMD_INIT:
                begin
                    if (!valid_reg[sidx])
                    begin
                        rst_mem[sidx] <= '0;
                        stp_mem[sidx] <= '0;
                        avg_mem[sidx] <= DEF_SLICE;
                    end
                    else if (av_q == '0)
                        avg_mem[sidx] <= DEF_SLICE;
                end
                CMD_ENABLE: tvt_mem[sidx] <= gvt_reg;
                CMD_RUNNING:
                    if (!simple_reg && valid_reg[sidx])
                        rst_mem[sidx] <= item_reg.now_ns;
                CMD_STOPPING:
                    if (!simple_reg && valid_reg[sidx])
                    begin
                        avg_mem[sidx] <= avg_new;
                        stp_mem[sidx] <= item_reg.now_ns;
                    end
                default: ;
            endcase
        end
        if (state_reg == S_CHARGE)
            tvt_mem[sidx] <= tv_q + quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            simple_reg <= 1'b0;
            isolate_reg <= 1'b1;
            aging_reg <= 16'd8;
            maxr_reg <= DEF_MAX_REMAINING_NS;
            shortr_reg <= DEF_SHORT_TASK_NS;
            ncpu_reg <= 13'd4096;
            gvt_reg <= '0;
            valid_reg <= '0;
            tvt_set_reg <= '0;
            div_second_reg <= 1'b0;
            cnt_reg <= '0;
            item_reg <= '0;
            out_reg <= '0;
            quo_reg <= '0;
            dvs_reg <= '0;
            rem_reg <= '0;
            est_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIMPLE_MODE:     simple_reg <= cfg_data[0];
                    REG_SOFTIRQ_ISOLATE: isolate_reg <= cfg_data[0];
                    REG_AGING_DIVISOR:   aging_reg <= cfg_data[15:0];
                    REG_MAX_REMAINING:   maxr_reg <= cfg_data;
                    REG_SHORT_TASK:      shortr_reg <= cfg_data;
                    REG_CPU_COUNT:       ncpu_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_data;
                        state_reg <= S_READ;
                    end
                S_READ: state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (item_reg.command == CMD_ENQUEUE)
                    begin
                        if (!slot_ok || (!simple_reg && !valid_reg[sidx]))
                        begin
                            out_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (simple_reg)
                        begin
                            out_reg <= simple_out;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            est_reg <= (av_q == '0) ? DEF_SLICE : av_q;
                            quo_reg <= (sp_q != '0) ? item_reg.now_ns - sp_q : '0;
                            dvs_reg <= (aging_reg == '0) ? 64'd1 : 64'(aging_reg);
                            rem_reg <= '0;
                            cnt_reg <= 7'd64;
                            div_second_reg <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                    else if (slot_ok && item_reg.command == CMD_STOPPING
                             && (simple_reg || valid_reg[sidx]))
                    begin
                        quo_reg <= used * NOMINAL_WEIGHT;
                        dvs_reg <= w_eff;
                        rem_reg <= '0;
                        cnt_reg <= 7'd64;
                        div_second_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        if (slot_ok)
                        begin
                            unique case (item_reg.command)
                                CMD_INIT: valid_reg[sidx] <= 1'b1;
                                CMD_ENABLE: tvt_set_reg[sidx] <= 1'b1;
                                CMD_RUNNING:
                                    if (simple_reg || valid_reg[sidx])
                                        if (((gvt_reg - tv_q) >> 63) != 64'd0)
                                            gvt_reg <= tv_q;
                                default: ;
                            endcase
                        end
                    end
                end
                S_DIV:
                begin
                    if (!rem_try[65])
                    begin
                        rem_reg <= rem_try[64:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        if (item_reg.command == CMD_STOPPING)
                            state_reg <= S_CHARGE;
                        else if (!div_second_reg)
                            state_reg <= S_EST;
                        else
                            state_reg <= S_KEYADD;
                    end
                end
                S_CHARGE:
                begin
                    tvt_set_reg[sidx] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_EST:
                begin
                    est_reg <= adj;
                    state_reg <= S_KEY;
                end
                S_KEY:
                begin
                    quo_reg <= est_reg * NOMINAL_WEIGHT;
                    dvs_reg <= w_eff;
                    rem_reg <= '0;
                    cnt_reg <= 7'd64;
                    div_second_reg <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_KEYADD:
                begin
                    out_reg <= key_out;
                    state_reg <= S_OUT;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `STDS_ASSERT_IMPL(a_div_count, state_reg == S_DIV, cnt_reg != 7'd0)
    `STDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `STDS_ASSERT_IMPL(a_fifo_simple, out_valid && out_data.fifo_order, out_data.order_key == '0)
endmodule
